// ===== rtl/sitd_pkg.sv =====
`default_nettype none

package sitd_pkg;

  localparam int DIGITS_MAX  = 10;
  localparam int K_W         = $clog2(DIGITS_MAX);
  localparam int VALUE_W     = 32;
  localparam int WIDE_W      = 34;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } entry_t;

  function automatic logic [WIDE_W-1:0] pow10(input logic [K_W-1:0] k);
    logic [WIDE_W-1:0] p;
    case (k)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      4'd10:   p = 34'd10000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// The first character reaches the result ports after the front register, the queue and the
//   sign or first emitted digit step of the sequencer; leading zeros are skipped silently.
// The sequencer pops a value only when idle, emits a minus sign if negative, then takes ten
//   digit steps, one power of ten per cycle unless a character waits on the result register.
// Front register and a two-entry queue let the next value enter during conversion.
// Reset (synchronous, rst_n low) empties the front stage, queue and result register.
`default_nettype none

module signed_int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = sitd_pkg::QUEUE_DEPTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  output logic        in_full,
  input  wire  [31:0] in_value,
  output logic        out_empty,
  input  wire         out_pop,
  output logic [7:0]  out_character,
  output logic        out_last
);

  sitd_pkg::entry_t wr_data;
  sitd_pkg::entry_t rd_data;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;

  sitd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_value (in_value),
    .q_push   (q_push),
    .q_full   (q_full),
    .q_data   (wr_data)
  );

  sitd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (rd_data),
    .empty   (q_empty)
  );

  sitd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .q_data        (rd_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

// ===== rtl/sitd_front.sv =====
`default_nettype none

module sitd_front (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_push,
  output logic                   in_full,
  input  wire  [31:0]            in_value,
  output logic                   q_push,
  input  wire                    q_full,
  output sitd_pkg::entry_t       q_data
);

  logic             vld_r, vld_nxt;
  sitd_pkg::entry_t entry_r, entry_nxt;
  logic             accept;

  assign in_full = vld_r & q_full;
  assign accept  = in_push & ~in_full;
  assign q_push  = vld_r & ~q_full;
  assign q_data  = entry_r;

  always_comb begin
    vld_nxt   = accept | (vld_r & q_full);
    entry_nxt = entry_r;
    if (accept) begin
      entry_nxt.neg = in_value[31];
      entry_nxt.mag = in_value[31] ? (32'd0 - in_value) : in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/sitd_fifo.sv =====
`default_nettype none

module sitd_fifo #(
  parameter int DEPTH = sitd_pkg::QUEUE_DEPTH
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     wr_en,
  input  sitd_pkg::entry_t        wr_data,
  output logic                    full,
  input  wire                     rd_en,
  output sitd_pkg::entry_t        rd_data,
  output logic                    empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sitd_pkg::entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/sitd_back.sv =====
`default_nettype none

module sitd_back (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    q_empty,
  output logic                   q_pop,
  input  sitd_pkg::entry_t       q_data,
  output logic                   out_empty,
  input  wire                    out_pop,
  output logic [7:0]             out_character,
  output logic                   out_last
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SIGN  = 3'b010,
    S_DIGIT = 3'b100
  } state_t;

  localparam int K_W = sitd_pkg::K_W;
  localparam int W_W = sitd_pkg::WIDE_W;
  localparam logic [K_W-1:0] K_TOP = K_W'(sitd_pkg::DIGITS_MAX - 1);

  state_t                         state_r, state_nxt;
  logic [sitd_pkg::VALUE_W-1:0]   mag_r, mag_nxt;
  logic [K_W-1:0]                 k_r, k_nxt;
  logic                           started_r, started_nxt;
  logic                           out_vld_r, out_vld_nxt;
  logic [7:0]                     char_r, char_nxt;
  logic                           last_r, last_nxt;

  logic [W_W-1:0] pow_k;
  logic [W_W-1:0] mag_w;
  logic [W_W-1:0] thr [10];
  logic [3:0]     dig;
  logic           emit_digit;
  logic           out_free;
  logic           step;

  assign out_empty     = ~out_vld_r;
  assign out_character = char_r;
  assign out_last      = last_r;

  assign pow_k = sitd_pkg::pow10(k_r);
  assign mag_w = W_W'(mag_r);

  always_comb begin
    thr[0] = '0;
    for (int m = 1; m < 10; m++) begin
      thr[m] = pow_k * W_W'(m);
    end
  end

  always_comb begin
    dig = '0;
    for (int m = 1; m < 10; m++) begin
      if (mag_w >= thr[m]) begin
        dig = 4'(m);
      end
    end
  end

  assign emit_digit = (dig != '0) || started_r || (k_r == '0);
  assign out_free   = ~out_vld_r | out_pop;
  assign step       = (state_r == S_DIGIT) && (!emit_digit || out_free);

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    k_nxt       = k_r;
    started_nxt = started_r;
    out_vld_nxt = out_vld_r & ~out_pop;
    char_nxt    = char_r;
    last_nxt    = last_r;
    q_pop       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          mag_nxt     = q_data.mag;
          k_nxt       = K_TOP;
          started_nxt = 1'b0;
          state_nxt   = q_data.neg ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          char_nxt    = sitd_pkg::CHAR_MINUS;
          last_nxt    = 1'b0;
          state_nxt   = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (step) begin
          mag_nxt     = mag_r - sitd_pkg::VALUE_W'(thr[dig]);
          started_nxt = started_r | emit_digit;
          if (emit_digit) begin
            out_vld_nxt = 1'b1;
            char_nxt    = sitd_pkg::CHAR_ZERO + {4'b0000, dig};
            last_nxt    = (k_r == '0);
          end
          if (k_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    k_r       <= k_nxt;
    started_r <= started_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

`ifndef ASSERT_OFF
  a_mag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGIT) |-> (mag_w < pow_k * W_W'(10)))
    else $error("remaining magnitude exceeds current digit span");
  a_sign_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIGN) |-> ((k_r == K_TOP) && !started_r))
    else $error("sign state entered mid-number");
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (k_r == '0)) |=> (state_r == S_IDLE) && out_vld_r && out_last)
    else $error("final digit not flagged last");
`endif

endmodule

`default_nettype wire
